@@ hw/rtl/lcac_pkg.sv @@
// Package with the shared types, constants and key folding function of the LRU cache.
`timescale 1ns / 1ps

package lcac_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W  = 64;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SIZE_W = 6;
  localparam int COST_W = 8;
  localparam int SUM_W  = 32;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_BIT     = 8'd32;

  // Byte addresses of the configuration registers.
  localparam logic [3:0] ADDR_CACHE_SIZE = 4'd0;
  localparam logic [3:0] ADDR_HIT_COST   = 4'd4;
  localparam logic [3:0] ADDR_MISS_COST  = 4'd8;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;
    logic upd;
    logic hit;
    logic size_nz;
    cnt_t keep;
    cnt_t count;
    key_t key;
  } lcac_ctrl_t;

  // Clears bytes beyond the key width and folds A to Z to lower case.
  function automatic key_t fold_key(key_t k);
    key_t       r;
    logic [7:0] b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (i >= KEY_BYTES) begin
        b = 8'd0;
      end
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
        b = b ^ CASE_BIT;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

  // A size above the capacity acts as the capacity.
  function automatic cnt_t eff_size(size_t cs);
    cnt_t r;
    if (int'(cs) > CAPACITY) begin
      r = cnt_t'(CAPACITY);
    end else begin
      r = cnt_t'(cs);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/lcac_cell.sv @@
// One slot of the LRU chain: a stored key, its compare and its shift from the neighbor.
`timescale 1ns / 1ps

module lcac_cell (
  input  logic                clk,
  input  lcac_pkg::lcac_ctrl_t ctrl,
  input  lcac_pkg::idx_t      idx,
  input  lcac_pkg::key_t      prev_key,
  input  logic                sel_in,
  output lcac_pkg::key_t      key,
  output logic                sel_out,
  output logic                match
);
  import lcac_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic match_r;
  logic match_nxt;
  logic slot_valid;
  logic load;

  assign slot_valid = cnt_t'(idx) < ctrl.count;

  // High when the hit lies in this slot or in any older one.
  assign sel_out = sel_in | match_r;

  assign load = ctrl.upd &&
                (ctrl.hit ? sel_out : (ctrl.size_nz && cnt_t'(idx) <= ctrl.keep));

  always_comb begin
    match_nxt = match_r;
    key_nxt   = key_r;
    if (ctrl.cmp) begin
      match_nxt = slot_valid && (key_r == ctrl.key);
    end
    if (load) begin
      key_nxt = prev_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    match_r <= match_nxt;
  end

  assign key   = key_r;
  assign match = match_r;

endmodule

@@ hw/rtl/lru_cache_access_cost.sv @@
// Top level of the fully associative LRU cache with access cost accounting.
`timescale 1ns / 1ps

// An item is accepted when start is high and busy is low. It then passes
// through ST_CMP and ST_UPD: first the case-folded key is registered, then
// the compare result in every cell, and last the chain of cells moves to
// its new LRU order and the result registers are loaded. The result strobe
// out_valid goes high in the same cycle as busy goes low again, so a new
// item can be accepted while the result is shown; a new item is not taken
// before the last one is through the compare stage and the shift stage.
// The receiver cannot stall: each result stands for exactly one cycle.
// No clearing pass runs after reset, since only slots below the fill count
// are ever compared. Configuration must be written over the APB port only
// while the block is idle; the block itself does not enforce this. Writing
// cache_size below the fill count drops the oldest entries at once.

module lru_cache_access_cost (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_key,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_access_cost,
  output logic [31:0] out_total_cost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcac_pkg::*;

  // One-hot sequencer for the three phases of an item.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  size_t  cache_size_r;
  size_t  cache_size_nxt;
  cost_t  hit_cost_r;
  cost_t  hit_cost_nxt;
  cost_t  miss_cost_r;
  cost_t  miss_cost_nxt;
  cnt_t   count_r;
  cnt_t   count_nxt;
  sum_t   cost_sum_r;
  sum_t   cost_sum_nxt;
  key_t   key_r;
  key_t   key_nxt;

  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_hit_r;
  logic   out_hit_nxt;
  cost_t  out_cost_r;
  cost_t  out_cost_nxt;
  sum_t   out_sum_r;
  sum_t   out_sum_nxt;

  logic   accept;
  logic   cfg_wr;
  cnt_t   size_eff;
  cnt_t   new_size;
  cnt_t   keep;
  logic   hit;
  cost_t  cost;
  logic [SUM_W:0] sum_wide;

  lcac_ctrl_t ctrl;
  key_t       cell_key [CAPACITY];
  logic       cell_sel [CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign size_eff = eff_size(cache_size_r);
  assign new_size = eff_size(pwdata[SIZE_W-1:0]);

  // Entries kept behind the new front entry on a miss.
  assign keep = (count_r < size_eff) ? count_r : (size_eff - cnt_t'(1));

  // The hit chain runs from the oldest cell down to cell zero.
  assign hit = cell_sel[0];

  assign cost     = hit ? hit_cost_r : miss_cost_r;
  assign sum_wide = {1'b0, cost_sum_r} + {{(SUM_W + 1 - COST_W){1'b0}}, cost};

  always_comb begin
    ctrl.cmp     = (state_r == ST_CMP);
    ctrl.upd     = (state_r == ST_UPD);
    ctrl.hit     = hit;
    ctrl.size_nz = (size_eff != '0);
    ctrl.keep    = keep;
    ctrl.count   = count_r;
    ctrl.key     = key_r;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      key_t prev_key;
      logic sel_in;
      if (g == 0) begin : g_head
        assign prev_key = key_r;
      end else begin : g_body
        assign prev_key = cell_key[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign sel_in = 1'b0;
      end else begin : g_link
        assign sel_in = cell_sel[g+1];
      end
      lcac_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .idx      (idx_t'(g)),
        .prev_key (prev_key),
        .sel_in   (sel_in),
        .key      (cell_key[g]),
        .sel_out  (cell_sel[g]),
        .match    (match_vec[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    cache_size_nxt = cache_size_r;
    hit_cost_nxt   = hit_cost_r;
    miss_cost_nxt  = miss_cost_r;
    count_nxt      = count_r;
    cost_sum_nxt   = cost_sum_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = out_hit_r;
    out_cost_nxt   = out_cost_r;
    out_sum_nxt    = out_sum_r;

    if (cfg_wr) begin
      case (paddr)
        ADDR_CACHE_SIZE: begin
          cache_size_nxt = pwdata[SIZE_W-1:0];
          if (count_r > new_size) begin
            count_nxt = new_size;
          end
        end
        ADDR_HIT_COST: begin
          hit_cost_nxt = pwdata[COST_W-1:0];
        end
        ADDR_MISS_COST: begin
          miss_cost_nxt = pwdata[COST_W-1:0];
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt   = fold_key(in_key);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!hit && size_eff != '0) begin
          count_nxt = keep + cnt_t'(1);
        end
        if (sum_wide[SUM_W]) begin
          cost_sum_nxt = '1;
        end else begin
          cost_sum_nxt = sum_wide[SUM_W-1:0];
        end
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit;
        out_cost_nxt  = cost;
        out_sum_nxt   = cost_sum_nxt;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cache_size_r <= '0;
      hit_cost_r   <= cost_t'(1);
      miss_cost_r  <= cost_t'(5);
      count_r      <= '0;
      cost_sum_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cache_size_r <= cache_size_nxt;
      hit_cost_r   <= hit_cost_nxt;
      miss_cost_r  <= miss_cost_nxt;
      count_r      <= count_nxt;
      cost_sum_r   <= cost_sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_hit_r  <= out_hit_nxt;
    out_cost_r <= out_cost_nxt;
    out_sum_r  <= out_sum_nxt;
  end

  always_comb begin
    case (paddr)
      ADDR_CACHE_SIZE: prdata = {{(32 - SIZE_W){1'b0}}, cache_size_r};
      ADDR_HIT_COST:   prdata = {{(32 - COST_W){1'b0}}, hit_cost_r};
      ADDR_MISS_COST:  prdata = {{(32 - COST_W){1'b0}}, miss_cost_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_access_cost = out_cost_r;
  assign out_total_cost  = out_sum_r;

  // Each accepted item yields its result strobe.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid_r)
    else $error("result strobe missing three cycles after an accepted item");

  // The fill count never exceeds the size in effect.
  a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= size_eff)
    else $error("fill count exceeds the configured cache size");

  // Stored keys are unique, so at most one cell can match.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  // The running total never goes down.
  a_sum_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cost_sum_r >= $past(cost_sum_r))
    else $error("running total cost decreased");

endmodule
